>>> rtl/rau_pkg.sv
// Shared types and constants for the rational arithmetic unit.
package rau_pkg;

  localparam logic [1:0] CMD_ADD = 2'd0;
  localparam logic [1:0] CMD_SUB = 2'd1;
  localparam logic [1:0] CMD_MUL = 2'd2;
  localparam logic [1:0] CMD_DIV = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_OVF  = 2'd2;

  // Datapath operations driven by the controller.
  typedef enum logic [2:0] {
    OP_NONE  = 3'd0,
    OP_LOAD  = 3'd1,
    OP_MUL   = 3'd2,
    OP_COMB  = 3'd3,
    OP_DSTEP = 3'd4,
    OP_DDONE = 3'd5,
    OP_FIN   = 3'd6
  } dp_op_t;

  // Datapath divider selection.
  typedef enum logic [1:0] {
    DV_GCD = 2'd0,
    DV_NUM = 2'd1,
    DV_DEN = 2'd2
  } dv_sel_t;

  typedef struct packed {
    dp_op_t  op;
    logic [1:0] mul_idx;
    dv_sel_t dv;
  } dp_cmd_t;

  typedef struct packed {
    logic in_err;
    logic num_zero;
    logic div_last;
    logic gcd_done;
  } dp_stat_t;

endpackage

>>> rtl/rau_datapath.sv
// Datapath: operand registers, shared multiplier and a restoring divider.
module rau_datapath import rau_pkg::*; #(
  parameter int W = 32
) (
  input  logic                 clk,
  input  dp_cmd_t              cmd_i,
  input  logic [1:0]           op_cmd,
  input  logic [31:0]          a_num,
  input  logic [31:0]          a_den,
  input  logic [31:0]          b_num,
  input  logic [31:0]          b_den,
  output dp_stat_t             stat,
  output logic [31:0]          res_num,
  output logic [30:0]          res_den,
  output logic [1:0]           status
);
  localparam int MW = 2 * W + 1;
  localparam int CW = $clog2(MW + 1);

  logic [W-1:0] mag [4];
  logic [3:0]   sgn;
  logic [1:0]   opc;
  logic [2*W-1:0] prod [3];
  logic [2:0]   psgn;
  logic [MW-1:0] nmag, dmag, gx, gy, rem, quo, dvd, dvs;
  logic          nneg;
  logic [CW-1:0] cnt;
  logic [MW-1:0] num_q;

  function automatic logic [W-1:0] absw(input logic [31:0] v);
    logic [W-1:0] t;
    t = v[W-1:0];
    return t[W-1] ? (~t + 1'b1) : t;
  endfunction

  logic [W-1:0] ma, mb;
  logic         ms;
  always_comb begin
    case (cmd_i.mul_idx)
      2'd0: begin
        ma = mag[0];
        mb = (opc == CMD_MUL) ? mag[2] : mag[3];
        ms = sgn[0] ^ ((opc == CMD_MUL) ? sgn[2] : sgn[3]);
      end
      2'd1: begin
        ma = mag[2];
        mb = mag[1];
        ms = sgn[2] ^ sgn[1] ^ (opc == CMD_SUB);
      end
      default: begin
        ma = mag[1];
        mb = (opc == CMD_DIV) ? mag[2] : mag[3];
        ms = sgn[1] ^ ((opc == CMD_DIV) ? sgn[2] : sgn[3]);
      end
    endcase
  end

  // One restoring division step: shift in the next dividend bit.
  logic [MW:0]   trial;
  logic [MW-1:0] rsh;
  always_comb begin
    rsh   = {rem[MW-2:0], dvd[MW-1]};
    trial = {1'b0, rsh} - {1'b0, dvs};
  end

  logic [MW-1:0] sn, sd;
  always_comb begin
    sn = {1'b0, prod[0]};
    sd = {1'b0, prod[1]};
  end

  assign stat.in_err   = (mag[1] == '0) || (mag[3] == '0) ||
                         (opc == CMD_DIV && mag[2] == '0);
  assign stat.num_zero = (nmag == '0);
  assign stat.div_last = (cnt == CW'(MW - 1));
  assign stat.gcd_done = (gy == '0);

  logic [W-1:0] half;
  assign half = {1'b1, {(W-1){1'b0}}};

  always_ff @(posedge clk) begin
    case (cmd_i.op)
      OP_LOAD: begin
        mag[0] <= absw(a_num); sgn[0] <= a_num[W-1];
        mag[1] <= absw(a_den); sgn[1] <= a_den[W-1];
        mag[2] <= absw(b_num); sgn[2] <= b_num[W-1];
        mag[3] <= absw(b_den); sgn[3] <= b_den[W-1];
        opc <= op_cmd;
      end
      OP_MUL: begin
        prod[cmd_i.mul_idx] <= ma * mb;
        psgn[cmd_i.mul_idx] <= ms;
      end
      OP_COMB: begin
        dmag <= {1'b0, prod[2]};
        if (opc == CMD_MUL || opc == CMD_DIV) begin
          nmag <= sn; nneg <= psgn[0];
        end else if (psgn[0] == psgn[1]) begin
          nmag <= sn + sd; nneg <= psgn[0];
        end else if (sn >= sd) begin
          nmag <= sn - sd; nneg <= psgn[0];
        end else begin
          nmag <= sd - sn; nneg <= psgn[1];
        end
      end
      default: ;
    endcase
    if (cmd_i.op == OP_COMB) cnt <= '0;
    // Divider start: pick operands.
    if (cmd_i.op == OP_DDONE || (cmd_i.op == OP_NONE && cmd_i.dv == DV_GCD &&
        cmd_i.mul_idx == 2'd3)) begin
      cnt <= '0; rem <= '0; quo <= '0;
      case (cmd_i.dv)
        DV_GCD: begin dvd <= gx; dvs <= gy; end
        DV_NUM: begin dvd <= nmag; dvs <= gx; end
        default: begin dvd <= dmag; dvs <= gx; end
      endcase
    end
    if (cmd_i.op == OP_DSTEP) begin
      dvd <= {dvd[MW-2:0], 1'b0};
      cnt <= cnt + 1'b1;
      if (!trial[MW]) begin
        rem <= trial[MW-1:0]; quo <= {quo[MW-2:0], 1'b1};
      end else begin
        rem <= rsh; quo <= {quo[MW-2:0], 1'b0};
      end
    end
    // Result of a finished division; dv tags what to do with it.
    if (cmd_i.op == OP_FIN) begin
      case (cmd_i.dv)
        DV_GCD: begin gx <= gy; gy <= rem; end
        DV_NUM: num_q <= quo;
        default: begin
          if (quo > MW'(half - 1'b1) ||
              (nneg ^ psgn[2] ? num_q > MW'(half) : num_q > MW'(half - 1'b1))) begin
            res_num <= '0; res_den <= '0; status <= ST_OVF;
          end else begin
            res_num <= 32'(signed'((nneg ^ psgn[2]) ? (~num_q[W-1:0] + 1'b1)
                                                    : num_q[W-1:0]));
            res_den <= 31'(quo[W-2:0]);
            status  <= ST_OK;
          end
        end
      endcase
    end
    if (cmd_i.op == OP_NONE && cmd_i.mul_idx == 2'd1) begin
      res_num <= '0; res_den <= '0; status <= ST_ZERO;
    end
    if (cmd_i.op == OP_NONE && cmd_i.mul_idx == 2'd2) begin
      res_num <= '0; res_den <= 31'd1; status <= ST_OK;
    end
    if (cmd_i.op == OP_COMB) begin
      gx <= (opc == CMD_MUL || opc == CMD_DIV) ? sn :
            (psgn[0] == psgn[1]) ? sn + sd : (sn >= sd) ? sn - sd : sd - sn;
      gy <= {1'b0, prod[2]};
    end
  end
endmodule

>>> rtl/rau_ctrl.sv
// Controller state machine sequencing load, multiply, gcd and the two divides.
module rau_ctrl import rau_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd_o
);
  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_CHK   = 10'b0000000010,
    S_MUL   = 10'b0000000100,
    S_COMB  = 10'b0000001000,
    S_ZCHK  = 10'b0000010000,
    S_GSET  = 10'b0000100000,
    S_DIV   = 10'b0001000000,
    S_FIN   = 10'b0010000000,
    S_NEXT  = 10'b0100000000,
    S_OUT   = 10'b1000000000
  } state_t;

  state_t state, state_next;
  logic [1:0] midx, midx_next;
  dv_sel_t dv, dv_next;

  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    state_next = state;
    midx_next  = midx;
    dv_next    = dv;
    cmd_o      = '{op: OP_NONE, mul_idx: 2'd0, dv: dv};
    case (state)
      S_IDLE: if (in_valid) begin
        cmd_o.op = OP_LOAD; state_next = S_CHK;
      end
      S_CHK: begin
        if (stat.in_err) begin
          cmd_o.mul_idx = 2'd1; state_next = S_OUT;
        end else begin
          midx_next = 2'd0; state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.op = OP_MUL; cmd_o.mul_idx = midx;
        midx_next = midx + 2'd1;
        if (midx == 2'd2) state_next = S_COMB;
      end
      S_COMB: begin cmd_o.op = OP_COMB; state_next = S_ZCHK; end
      S_ZCHK: begin
        if (stat.num_zero) begin
          cmd_o.mul_idx = 2'd2; state_next = S_OUT;
        end else begin
          dv_next = DV_GCD; state_next = S_GSET;
        end
      end
      S_GSET: begin
        if (dv == DV_GCD && stat.gcd_done) begin
          dv_next = DV_NUM; cmd_o.dv = DV_NUM;
        end
        cmd_o.op = OP_DDONE; state_next = S_DIV;
      end
      S_DIV: begin
        cmd_o.op = OP_DSTEP;
        if (stat.div_last) state_next = S_FIN;
      end
      S_FIN: begin
        cmd_o.op = OP_FIN;
        case (dv)
          DV_GCD:  state_next = S_GSET;
          DV_NUM:  begin dv_next = DV_DEN; state_next = S_NEXT; end
          default: state_next = S_OUT;
        endcase
      end
      S_NEXT: begin cmd_o.op = OP_DDONE; state_next = S_DIV; end
      S_OUT: if (!out_stall) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; midx <= '0; dv <= DV_GCD;
    end else begin
      state <= state_next; midx <= midx_next; dv <= dv_next;
    end
  end
endmodule

>>> rtl/rational_arith_unit.sv
// Top level of the rational arithmetic unit: controller plus datapath.
// Computes a op b on two signed fractions (add, subtract, multiply, divide)
// and returns the result reduced to lowest terms with the sign in the
// numerator; a zero result is 0/1. A zero denominator, or a zero divisor in
// divide, gives status 1 with zero fields; a reduced result outside the
// OPERAND_WIDTH signed range gives status 2 with zero fields. One item is
// in flight at a time. The next item can be accepted once the unit is back
// in idle after the result is taken. Each remainder and both final quotients
// go through one shared restoring divider retiring one bit per cycle over a
// 2W+1 bit word, where W is OPERAND_WIDTH. The three cross products share
// one multiplier, one per cycle.
module rational_arith_unit import rau_pkg::*; #(
  parameter int OPERAND_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  cmd,
  input  logic [31:0] a_num,
  input  logic [31:0] a_den,
  input  logic [31:0] b_num,
  input  logic [31:0] b_den,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] res_num,
  output logic [30:0] res_den,
  output logic [1:0]  status
);
  dp_cmd_t  dcmd;
  dp_stat_t dstat;

  // Sequence each item through the datapath.
  rau_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall,
    .stat(dstat), .cmd_o(dcmd)
  );

  // Hold operands, products, gcd and result.
  rau_datapath #(.W(OPERAND_WIDTH)) u_dp (
    .clk, .cmd_i(dcmd), .op_cmd(cmd), .a_num, .a_den, .b_num, .b_den,
    .stat(dstat), .res_num, .res_den, .status
  );

  // Stall input while a result is pending.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("accepting while result pending");
  // A held result stays put.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(res_num) && $stable(status))
    else $error("result changed while stalled");
  // An ok result never has a zero denominator.
  a_den_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_OK |-> res_den != '0) else $error("zero den");
endmodule
